// ===== rtl/bpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PoolPagesMax = 4096;
  localparam int unsigned AddrW        = $clog2(PoolPagesMax);
  localparam int unsigned CountW       = AddrW + 1;
  localparam int unsigned TopOrder     = 11;
  localparam int unsigned OrdW         = 4;
  localparam int unsigned PageShift    = 12;  // 4096-byte pages
  localparam int unsigned HeaderBytes  = 16;
  localparam int unsigned TagW         = 6;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_ALLOC    = 2'd2,
    KIND_RELEASED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FORMAT  = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_INVALID   = 3'd5
  } status_e;

  typedef struct packed {
    kind_e           kind;
    logic [OrdW-1:0] order;
  } tag_t;

  // Smallest n with 2^n >= pages.
  function automatic logic [OrdW-1:0] need_order(input logic [CountW-1:0] pages);
    logic [OrdW-1:0] n;
    n = OrdW'(CountW);
    for (int i = CountW - 1; i >= 0; i--) begin
      if ((CountW+1)'(pages) <= ((CountW+1)'(1) << i)) n = OrdW'(i);
    end
    return n;
  endfunction

  // Largest n <= TopOrder with 2^n <= rem (rem non-zero).
  function automatic logic [OrdW-1:0] carve_order(input logic [CountW-1:0] rem);
    logic [OrdW-1:0] n;
    n = '0;
    for (int i = 0; i <= int'(TopOrder); i++) begin
      if (rem >= (CountW'(1) << i)) n = OrdW'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bpa_tag_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_tag_ram
// Per-page tag store, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_tag_ram import bpa_pkg::*; (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  tag_t             wdata_i,
  input  wire [AddrW-1:0]  raddr_i,
  output tag_t             rdata_o
);

  tag_t mem [PoolPagesMax];
  tag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Binary buddy allocator over a pool of up to 4096 pages, one operation at a time.
// ----------------------------------------------------------------------------
// One word in gives one word out. Every operation runs through a small
// sequencer around a tag RAM with one write and one read port (one tag per
// page), so the cost is set by RAM accesses: after reset the RAM is swept
// clear of all 4096 tags before the first word is taken. Format sweeps all
// 4096 tags, one a cycle, writing the free heads as it goes. Allocate scans
// all tags once for the smallest free order at the lowest address, then
// writes one split buddy a cycle (up to 11) and the head. Release checks the
// tag, then reads and checks the buddy for each merge level and writes the
// merged head. Size errors and the unused opcode answer straight from idle,
// release errors after the tag check. The result sits in an output register;
// a new word is taken once the sequencer is idle and that register is empty.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit import bpa_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [12:0] cfg_wdata_i,    // pool_pages
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i, // [23:0] request_bytes, [35:24] release_page
  input  wire  [1:0]  s_axis_tuser_i, // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o  // [2:0] status, [14:3] block_page,
                                      // [18:15] block_order, [31:19] free_page_count
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FORMAT, S_SCAN, S_SPLIT,
    S_REL_CHK, S_MRG_RD, S_MRG_CHK, S_MRG_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   pool_q, pool_d;
  logic [CountW-1:0]   free_q, free_d;
  logic [CountW-1:0]   cnt_q, cnt_d;      // sweep / scan position
  logic [CountW-1:0]   fcur_q, fcur_d;    // next head while carving
  logic [CountW-1:0]   frem_q, frem_d;    // pages still to carve
  logic [AddrW-1:0]    page_q, page_d;
  logic [OrdW-1:0]     ord_q, ord_d;
  logic [OrdW-1:0]     need_q, need_d;
  logic [OrdW-1:0]     best_q, best_d;    // all ones: nothing found
  logic                ovld_q, ovld_d;
  logic [2:0]          ost_q, ost_d;
  logic [AddrW-1:0]    opg_q, opg_d;
  logic [OrdW-1:0]     oord_q, oord_d;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  tag_t                wdata, rdata;

  bpa_tag_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [23:0]       req_bytes;
  logic [AddrW-1:0]  rel_page;
  logic [24:0]       total_bytes;
  logic [CountW-1:0] req_pages;
  logic [OrdW-1:0]   req_need;
  logic [OrdW-1:0]   carve;
  logic [AddrW-1:0]  bud;
  logic              accept;

  assign req_bytes   = s_axis_tdata_i[23:0];
  assign rel_page    = s_axis_tdata_i[35:24];
  assign total_bytes = 25'(req_bytes) + 25'(HeaderBytes);
  assign req_pages   = CountW'((26'(total_bytes) + 26'((1 << PageShift) - 1)) >> PageShift);
  assign req_need    = need_order(req_pages);
  assign carve       = carve_order(frem_q);
  assign bud         = page_q ^ (AddrW'(1) << ord_q);

  assign s_axis_tready_o = (state_q == S_IDLE) && !ovld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {free_q, oord_q, opg_q, ost_q};

  always_comb begin
    state_d = state_q;
    pool_d  = cfg_we_i ? cfg_wdata_i : pool_q;
    free_d  = free_q;
    cnt_d   = cnt_q;
    fcur_d  = fcur_q;
    frem_d  = frem_q;
    page_d  = page_q;
    ord_d   = ord_q;
    need_d  = need_q;
    best_d  = best_q;
    ovld_d  = ovld_q && !m_axis_tready_i;
    ost_d   = ost_q;
    opg_d   = opg_q;
    oord_d  = oord_q;
    we      = 1'b0;
    waddr   = cnt_q[AddrW-1:0];
    wdata   = '{kind: KIND_NONE, order: '0};
    raddr   = cnt_q[AddrW-1:0];

    case (state_q)
      S_CLEAR, S_FORMAT: begin
        // Sweep every tag; carve heads as the sweep passes them.
        we = 1'b1;
        if (frem_q != '0 && cnt_q == fcur_q) begin
          wdata  = '{kind: KIND_FREE, order: carve};
          fcur_d = fcur_q + (CountW'(1) << carve);
          frem_d = frem_q - (CountW'(1) << carve);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CountW'(PoolPagesMax - 1)) begin
          state_d = S_IDLE;
          if (state_q == S_FORMAT) begin
            ovld_d = 1'b1;
            ost_d  = ST_OK;
            opg_d  = '0;
            oord_d = '0;
          end
        end
      end

      S_IDLE: begin
        if (accept) begin
          ost_d  = ST_OK;
          opg_d  = '0;
          oord_d = '0;
          cnt_d  = '0;
          case (opcode_e'(s_axis_tuser_i))
            OP_ALLOC: begin
              if (req_bytes == '0) begin
                ost_d  = ST_ZERO;
                ovld_d = 1'b1;
              end else if (req_need > OrdW'(TopOrder)) begin
                ost_d  = ST_TOO_LARGE;
                ovld_d = 1'b1;
              end else begin
                need_d  = req_need;
                best_d  = '1;
                state_d = S_SCAN;
              end
            end
            OP_RELEASE: begin
              page_d  = rel_page;
              raddr   = rel_page;
              state_d = S_REL_CHK;
            end
            OP_FORMAT: begin
              frem_d  = (pool_q > CountW'(PoolPagesMax)) ? CountW'(PoolPagesMax) : pool_q;
              free_d  = (pool_q > CountW'(PoolPagesMax)) ? CountW'(PoolPagesMax) : pool_q;
              fcur_d  = '0;
              state_d = S_FORMAT;
            end
            default: begin
              ovld_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read address cnt, judge the tag read at cnt-1.
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && rdata.kind == KIND_FREE && rdata.order >= need_q &&
            rdata.order < best_q) begin
          best_d = rdata.order;
          page_d = AddrW'(cnt_q - 1'b1);
        end
        if (cnt_q == CountW'(PoolPagesMax)) begin
          if (best_d == '1) begin
            ost_d   = ST_NO_MEM;
            ovld_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            ord_d   = best_d;
            state_d = S_SPLIT;
          end
        end
      end

      S_SPLIT: begin
        we = 1'b1;
        if (ord_q > need_q) begin
          waddr = page_q | (AddrW'(1) << (ord_q - 1'b1));
          wdata = '{kind: KIND_FREE, order: ord_q - 1'b1};
          ord_d = ord_q - 1'b1;
        end else begin
          waddr   = page_q;
          wdata   = '{kind: KIND_ALLOC, order: need_q};
          free_d  = free_q - (CountW'(1) << need_q);
          opg_d   = page_q;
          oord_d  = need_q;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_REL_CHK: begin
        if (rdata.kind == KIND_FREE || rdata.kind == KIND_RELEASED) begin
          ost_d   = ST_DOUBLE;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end else if (rdata.kind != KIND_ALLOC) begin
          ost_d   = ST_INVALID;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ord_d   = (rdata.order > OrdW'(TopOrder)) ? OrdW'(TopOrder) : rdata.order;
          we      = 1'b1;
          waddr   = page_q;
          wdata   = '{kind: KIND_RELEASED, order: ord_d};
          free_d  = free_q + (CountW'(1) << ord_d);
          state_d = (ord_d < OrdW'(TopOrder)) ? S_MRG_RD : S_MRG_FIN;
        end
      end

      S_MRG_RD: begin
        raddr   = bud;
        state_d = S_MRG_CHK;
      end

      S_MRG_CHK: begin
        if (rdata.kind == KIND_FREE && rdata.order == ord_q) begin
          we      = 1'b1;
          waddr   = bud;
          wdata   = '{kind: KIND_NONE, order: '0};
          page_d  = (bud < page_q) ? bud : page_q;
          ord_d   = ord_q + 1'b1;
          state_d = (ord_d < OrdW'(TopOrder)) ? S_MRG_RD : S_MRG_FIN;
        end else begin
          state_d = S_MRG_FIN;
        end
      end

      S_MRG_FIN: begin
        we      = 1'b1;
        waddr   = page_q;
        wdata   = '{kind: KIND_FREE, order: ord_q};
        opg_d   = page_q;
        oord_d  = ord_q;
        ovld_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pool_q  <= CountW'(PoolPagesMax);
      free_q  <= '0;
      cnt_q   <= '0;
      fcur_q  <= '0;
      frem_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pool_q  <= pool_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      fcur_q  <= fcur_d;
      frem_q  <= frem_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    ord_q  <= ord_d;
    need_q <= need_d;
    best_q <= best_d;
    ost_q  <= ost_d;
    opg_q  <= opg_d;
    oord_q <= oord_d;
  end

endmodule
`default_nettype wire

// ===== bench/tb_buddy_page_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator_unit
// Self-checking bench for the buddy page allocator.
// ----------------------------------------------------------------------------
// Words go in on the slave stream and every word gives one result word.
// The bench keeps its own tag array and free count, predicts each result when
// the input word is accepted, and compares results field by field in order.
// A short directed table comes first, then random traffic over several pool
// sizes, with idle gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator_unit;
  import bpa_pkg::*;

  typedef struct {
    status_e      st;
    logic [11:0]  page;
    logic [3:0]   ord;
    logic [12:0]  cnt;
  } alloc_result_t;

  typedef struct {
    opcode_e       op;
    logic [23:0]   bytes;
    logic [11:0]   page;
    bit            typed;
    alloc_result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  buddy_page_allocator_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow state of the allocator
  tag_t        shadow_tag [PoolPagesMax];
  logic [12:0] shadow_free;
  logic [12:0] shadow_pool;
  int          live_pages[$];     // heads currently allocated

  alloc_result_t pending_q[$];    // expected results, oldest first
  stim_row_t     directed_q[$];
  int            mismatches;
  int            results_seen;
  int            send_idle_pct;
  int            recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("[buddy_page_allocator_unit] ERROR");
    $finish;
  end

  // -------------------------------------------------------------- predictor
  function automatic alloc_result_t mk_res(status_e st, int page, int ord);
    alloc_result_t r;
    r.st   = st;
    r.page = page[11:0];
    r.ord  = ord[3:0];
    r.cnt  = shadow_free;
    return r;
  endfunction

  function automatic void carve_pool();
    int rem;
    int pos;
    int ord;
    rem = (shadow_pool > PoolPagesMax) ? PoolPagesMax : int'(shadow_pool);
    pos = 0;
    for (int i = 0; i < PoolPagesMax; i++) shadow_tag[i] = '{KIND_NONE, 4'd0};
    shadow_free = rem[12:0];
    live_pages.delete();
    while (rem >= 1) begin
      ord = TopOrder;
      while (ord > 0 && (1 << ord) > rem) ord--;
      shadow_tag[pos] = '{KIND_FREE, ord[3:0]};
      pos += 1 << ord;
      rem -= 1 << ord;
    end
  endfunction

  function automatic alloc_result_t take_block(logic [23:0] bytes);
    int pages;
    int need;
    int blk;
    int cur;
    bit found;
    if (bytes == 0) return mk_res(ST_ZERO, 0, 0);
    pages = (int'(bytes) + HeaderBytes + 4095) >> PageShift;
    need = 0;
    while ((1 << need) < pages) need++;
    if (need > TopOrder) return mk_res(ST_TOO_LARGE, 0, 0);
    found = 0;
    blk   = 0;
    cur   = need;
    // smallest order first, lowest address within it
    for (int o = need; o <= TopOrder && !found; o++) begin
      for (int p = 0; p < PoolPagesMax; p++) begin
        if (shadow_tag[p].kind == KIND_FREE && shadow_tag[p].order == o[3:0]) begin
          blk   = p;
          cur   = o;
          found = 1;
          break;
        end
      end
    end
    if (!found) return mk_res(ST_NO_MEM, 0, 0);
    while (cur > need) begin
      cur--;
      shadow_tag[blk + (1 << cur)] = '{KIND_FREE, cur[3:0]};
    end
    shadow_tag[blk] = '{KIND_ALLOC, need[3:0]};
    shadow_free -= 13'(1 << need);
    live_pages.push_back(blk);
    return mk_res(ST_OK, blk, need);
  endfunction

  function automatic alloc_result_t give_back_block(logic [11:0] page_in);
    int page;
    int ord;
    int bud;
    page = page_in;
    if (shadow_tag[page].kind inside {KIND_FREE, KIND_RELEASED})
      return mk_res(ST_DOUBLE, 0, 0);
    if (shadow_tag[page].kind != KIND_ALLOC) return mk_res(ST_INVALID, 0, 0);
    foreach (live_pages[i]) if (live_pages[i] == page) begin
      live_pages.delete(i);
      break;
    end
    ord = shadow_tag[page].order;
    if (ord > TopOrder) ord = TopOrder;
    // the head keeps a released mark; it goes stale if a buddy absorbs it
    shadow_tag[page] = '{KIND_RELEASED, ord[3:0]};
    shadow_free += 13'(1 << ord);
    while (ord < TopOrder) begin
      bud = page ^ (1 << ord);
      if (shadow_tag[bud].kind != KIND_FREE || shadow_tag[bud].order != ord[3:0]) break;
      shadow_tag[bud] = '{KIND_NONE, 4'd0};
      if (bud < page) page = bud;
      ord++;
    end
    shadow_tag[page] = '{KIND_FREE, ord[3:0]};
    return mk_res(ST_OK, page, ord);
  endfunction

  function automatic alloc_result_t predict_page_op(opcode_e op, logic [23:0] bytes,
                                                    logic [11:0] page);
    case (op)
      OP_ALLOC:   return take_block(bytes);
      OP_RELEASE: return give_back_block(page);
      OP_FORMAT: begin
        carve_pool();
        return mk_res(ST_OK, 0, 0);
      end
      default:    return mk_res(ST_OK, 0, 0);
    endcase
  endfunction

  // ----------------------------------------------------------------- driver
  // Offers one word; valid stays high into the next word unless a gap follows.
  task automatic send_word(opcode_e op, logic [23:0] bytes, logic [11:0] page,
                           bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, page, bytes};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = predict_page_op(op, bytes, page);
    pending_q.push_back(typed ? typed_res : r);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_pool_pages(logic [12:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_pool = val;
  endtask

  task automatic add_row(opcode_e op, logic [23:0] bytes, logic [11:0] page, bit typed,
                         status_e st, int cnt);
    stim_row_t row;
    row.op        = op;
    row.bytes     = bytes;
    row.page      = page;
    row.typed     = typed;
    row.res.st    = st;
    row.res.page  = '0;
    row.res.ord   = '0;
    row.res.cnt   = cnt[12:0];
    directed_q.push_back(row);
  endtask

  // Mostly allocate/release of live blocks; some noise and broken frees.
  task automatic random_traffic(int n_items, int base_idx, int total_items);
    int pick;
    int ord;
    int idx;
    logic [23:0] bytes;
    logic [11:0] page;
    opcode_e op;
    alloc_result_t none;
    none = '{ST_OK, '0, '0, '0};
    for (int i = 0; i < n_items; i++) begin
      idx = base_idx + i;
      // idling pattern moves through three stages over the random run
      if (idx * 3 < total_items) begin
        send_idle_pct = 13; recv_idle_pct = 62;
      end else if (idx * 3 < 2 * total_items) begin
        send_idle_pct = 62; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      pick  = $urandom_range(99);
      bytes = 24'($urandom);
      page  = 12'($urandom);
      if (pick < 45) begin
        op  = OP_ALLOC;
        ord = ($urandom_range(9) == 0) ? $urandom_range(TopOrder) : $urandom_range(3);
        if (pick < 3) bytes = (pick == 0) ? 24'd0 : 24'($urandom);
        else bytes = 24'($urandom_range((1 << ord) * 4096 - HeaderBytes, 1));
      end else if (pick < 90) begin
        op = OP_RELEASE;
        if (pick < 82 && live_pages.size() != 0)
          page = 12'(live_pages[$urandom_range(live_pages.size() - 1)]);
      end else if (pick < 94) begin
        op = OP_FORMAT;
      end else begin
        op = (pick < 97) ? OP_NOP : OP_RELEASE;
      end
      send_word(op, bytes, page, 1'b0, none);
    end
  endtask

  // --------------------------------------------------------------- receiver
  initial begin
    alloc_result_t exp_r;
    alloc_result_t got;
    int hold_left;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got.st   = status_e'(m_axis_tdata_o[2:0]);
        got.page = m_axis_tdata_o[14:3];
        got.ord  = m_axis_tdata_o[18:15];
        got.cnt  = m_axis_tdata_o[31:19];
        results_seen++;
        if (results_seen == 150) hold_left = 400;  // long stall, block fills up
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata_o);
        end else begin
          exp_r = pending_q.pop_front();
          if (got.st !== exp_r.st || got.page !== exp_r.page || got.ord !== exp_r.ord ||
              got.cnt !== exp_r.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp st %0d page %0d ord %0d free %0d, got %0d %0d %0d %0d",
                       results_seen, exp_r.st, exp_r.page, exp_r.ord, exp_r.cnt,
                       got.st, got.page, got.ord, got.cnt);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------- sequence
  initial begin
    alloc_result_t none;
    int unsigned pool_sizes [5];
    int          item_counts[5];
    int          done;
    none = '{ST_OK, '0, '0, '0};
    mismatches      = 0;
    results_seen    = 0;
    send_idle_pct   = 13;
    recv_idle_pct   = 62;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_NOP;
    shadow_pool     = 13'd4096;
    shadow_free     = '0;
    for (int i = 0; i < PoolPagesMax; i++) shadow_tag[i] = '{KIND_NONE, 4'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // before any format the pool is empty
    add_row(OP_ALLOC,   24'd1,        12'd0,   1, ST_NO_MEM,    0);
    add_row(OP_ALLOC,   24'd0,        12'd0,   1, ST_ZERO,      0);
    add_row(OP_ALLOC,   24'hFFFFFF,   12'd0,   1, ST_TOO_LARGE, 0);
    add_row(OP_RELEASE, 24'd0,        12'd0,   1, ST_INVALID,   0);
    add_row(OP_RELEASE, 24'hFFFFFF,   12'hFFF, 1, ST_INVALID,   0);
    add_row(OP_NOP,     24'hFFFFFF,   12'hFFF, 1, ST_OK,        0);
    add_row(OP_FORMAT,  24'd0,        12'd0,   1, ST_OK,        4096);
    // exact page boundaries, largest block, splits and merges
    add_row(OP_ALLOC,   24'd1,        12'd0,   0, ST_OK, 0);
    add_row(OP_ALLOC,   24'd4080,     12'd0,   0, ST_OK, 0);
    add_row(OP_ALLOC,   24'd4081,     12'd0,   0, ST_OK, 0);
    add_row(OP_ALLOC,   24'd8388592,  12'd0,   0, ST_OK, 0);
    add_row(OP_ALLOC,   24'd8388593,  12'd0,   0, ST_OK, 0);
    add_row(OP_ALLOC,   24'd8388592,  12'd0,   0, ST_OK, 0);
    add_row(OP_RELEASE, 24'd0,        12'd3,   0, ST_OK, 0);
    add_row(OP_RELEASE, 24'd0,        12'd1,   0, ST_OK, 0);
    add_row(OP_RELEASE, 24'd0,        12'd0,   0, ST_OK, 0);
    add_row(OP_RELEASE, 24'd0,        12'd1,   0, ST_OK, 0);   // tag cleared by the merge
    add_row(OP_RELEASE, 24'd0,        12'd0,   0, ST_OK, 0);   // free head
    add_row(OP_RELEASE, 24'd0,        12'd2048, 0, ST_OK, 0);
    add_row(OP_RELEASE, 24'd0,        12'd2,   0, ST_OK, 0);
    add_row(OP_NOP,     24'd0,        12'd0,   0, ST_OK, 0);
    foreach (directed_q[i])
      send_word(directed_q[i].op, directed_q[i].bytes, directed_q[i].page,
                directed_q[i].typed, directed_q[i].res);

    // pool sizes: smallest, above the maximum, empty, random, full
    pool_sizes  = '{1, 8191, 0, $urandom_range(4095, 2), 4096};
    item_counts = '{40, 60, 40, 220, 240};
    done = 0;
    foreach (pool_sizes[k]) begin
      drain_and_idle();
      write_pool_pages(13'(pool_sizes[k]));
      send_word(OP_FORMAT, 24'($urandom), 12'($urandom), 1'b0, none);
      random_traffic(item_counts[k], done, 600);
      done += item_counts[k];
    end

    drain_and_idle();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[buddy_page_allocator_unit] OK");
    end else begin
      $display("[buddy_page_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
